FILE: rtl/core/i2cms_pkg.sv
package i2cms_pkg;

  localparam int unsigned TpmW    = 8;
  localparam int unsigned TmoW    = 8;
  localparam int unsigned HoldW   = 12;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned BitsPerByte = 8;

  localparam logic [TpmW-1:0] TpmReset = TpmW'(72);
  localparam logic [TmoW-1:0] TmoReset = TmoW'(250);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_US = 1'b0,
    CFG_ACK_TIMEOUT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [OpW-1:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_SEND  = 3'd2,
    OP_READ  = 3'd3,
    OP_WAIT  = 3'd4,
    OP_ACK   = 3'd5
  } op_e;

  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             sda_drive;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] rx_byte;
    logic             ack_error;
  } result_t;

endpackage

FILE: rtl/core/i2cms_in_if.sv
interface i2cms_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd_valid;
  logic [i2cms_pkg::OpW-1:0]   operation;
  logic [i2cms_pkg::ByteW-1:0] tx_byte;
  logic                        send_ack;
  logic                        sda_in;

  modport source (output valid, cmd_valid, operation, tx_byte, send_ack, sda_in,
                  input ready);
  modport sink   (input valid, cmd_valid, operation, tx_byte, send_ack, sda_in,
                  output ready);
endinterface

FILE: rtl/core/i2cms_out_if.sv
interface i2cms_out_if;
  logic                        valid;
  logic                        ready;
  logic                        scl_level;
  logic                        sda_level;
  logic                        sda_drive;
  logic                        busy_res;
  logic                        done_res;
  logic [i2cms_pkg::ByteW-1:0] rx_byte;
  logic                        ack_error;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_error, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_error, output ready);
endinterface

FILE: rtl/core/i2c_master_byte_sequencer_top.sv
// Channel | Dir | Payload                                            | Rate
// in_i    | in  | cmd_valid, operation, tx_byte, send_ack, sda_in   | 1 item/cycle
// out_o   | out | scl/sda level, sda_drive, busy, done, rx, ack_err  | 1 item/cycle
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i                    | any idle cycle
//
// Each item (one line tick) is processed in the cycle it is accepted: the
// sequencer state and its result update at that edge.
// Results go through a 2-entry output buffer; in_i.ready drops only when it is
// full, so a stalled sink stalls the input and nothing else.
// Reset: idle, SCL/SDA high and driven, 72 ticks per us, ack timeout 250.
module i2c_master_byte_sequencer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  i2cms_in_if.sink                        in_i,
  i2cms_out_if.source                     out_o,
  input  logic                            cfg_we_i,
  input  logic [i2cms_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [i2cms_pkg::TpmW-1:0]      cfg_data_i
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_SP_C,
    PH_WA_A, PH_WA_B, PH_WA_POLL, PH_TX_SET, PH_TX_HI, PH_TX_LO,
    PH_RX_LO, PH_RX_HI, PH_AK_A, PH_AK_B
  } phase_e;

  localparam int unsigned HoldW = i2cms_pkg::HoldW;
  localparam int unsigned ByteW = i2cms_pkg::ByteW;

  // configuration
  logic [i2cms_pkg::TpmW-1:0] tpm_q;
  logic [i2cms_pkg::TmoW-1:0] tmo_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q     <= i2cms_pkg::TpmReset;
      tmo_lim_q <= i2cms_pkg::TmoReset;
    end else if (cfg_we_i) begin
      unique case (i2cms_pkg::cfg_idx_e'(cfg_idx_i))
        i2cms_pkg::CFG_TICKS_PER_US: tpm_q     <= cfg_data_i;
        i2cms_pkg::CFG_ACK_TIMEOUT:  tmo_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_e                          phase_q, phase_d;
  logic [HoldW-1:0]                hold_q, hold_d;
  logic [i2cms_pkg::BitCntW-1:0]   bit_q, bit_d;
  logic [ByteW-1:0]                shift_q, shift_d;
  logic [i2cms_pkg::TmoW-1:0]      tmo_q, tmo_d;
  logic                            ackb_q, ackb_d;
  logic                            scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
  logic                            err_q, err_d;
  logic [ByteW-1:0]                rx_q, rx_d;
  logic                            done_c, do_poll;

  logic                            in_fire, out_fire;

  // hold lengths of 1, 2 and 5 us
  logic [HoldW-1:0] tick_us, hold1, hold2, hold5;
  assign tick_us = (tpm_q == '0) ? HoldW'(1) : HoldW'(tpm_q);
  assign hold1   = tick_us;
  assign hold2   = tick_us << 1;
  assign hold5   = (tick_us << 2) + tick_us;

  always_comb begin
    phase_d = phase_q;
    hold_d  = hold_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    tmo_d   = tmo_q;
    ackb_d  = ackb_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drv_d   = drv_q;
    err_d   = err_q;
    rx_d    = rx_q;
    done_c  = 1'b0;
    do_poll = 1'b0;
    if (in_fire) begin
      priority if (phase_q == PH_IDLE) begin
        if (in_i.cmd_valid) begin
          ackb_d = in_i.send_ack;
          unique case (i2cms_pkg::op_e'(in_i.operation))
            i2cms_pkg::OP_START: begin
              drv_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
              phase_d = PH_ST_A; hold_d = hold5;
            end
            i2cms_pkg::OP_STOP: begin
              drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
              phase_d = PH_SP_A; hold_d = hold5;
            end
            i2cms_pkg::OP_SEND: begin
              drv_d = 1'b1; scl_d = 1'b0;
              sda_d   = in_i.tx_byte[ByteW-1];
              shift_d = in_i.tx_byte << 1;
              bit_d   = i2cms_pkg::BitCntW'(1);
              phase_d = PH_TX_SET; hold_d = hold2;
            end
            i2cms_pkg::OP_READ: begin
              sda_d = 1'b0; drv_d = 1'b0; scl_d = 1'b0;
              shift_d = '0; bit_d = '0;
              phase_d = PH_RX_LO; hold_d = hold5;
            end
            i2cms_pkg::OP_WAIT: begin
              err_d = 1'b0; tmo_d = '0;
              scl_d = 1'b0; drv_d = 1'b0;
              phase_d = PH_WA_A; hold_d = hold2;
            end
            i2cms_pkg::OP_ACK: begin
              scl_d = 1'b0; drv_d = 1'b1; sda_d = ~in_i.send_ack;
              phase_d = PH_AK_A; hold_d = hold2;
            end
            default: ;  // undefined operations are dropped
          endcase
        end
      end else if (phase_q == PH_WA_POLL) begin
        do_poll = 1'b1;
      end else if (hold_q > HoldW'(1)) begin
        hold_d = hold_q - HoldW'(1);
      end else begin
        unique case (phase_q)
          PH_ST_A:   begin sda_d = 1'b0; phase_d = PH_ST_B; hold_d = hold5; end
          PH_ST_B:   begin scl_d = 1'b0; phase_d = PH_IDLE; hold_d = '0; done_c = 1'b1; end
          PH_SP_A:   begin scl_d = 1'b1; phase_d = PH_SP_B; hold_d = hold1; end
          PH_SP_B:   begin sda_d = 1'b1; phase_d = PH_SP_C; hold_d = hold5; end
          PH_WA_A:   begin scl_d = 1'b1; phase_d = PH_WA_B; hold_d = hold2; end
          PH_WA_B:   begin phase_d = PH_WA_POLL; hold_d = '0; do_poll = 1'b1; end
          PH_TX_SET: begin scl_d = 1'b1; phase_d = PH_TX_HI; hold_d = hold5; end
          PH_TX_HI:  begin scl_d = 1'b0; phase_d = PH_TX_LO; hold_d = hold2; end
          PH_TX_LO: begin
            if (bit_q >= i2cms_pkg::BitCntW'(i2cms_pkg::BitsPerByte)) begin
              phase_d = PH_IDLE; hold_d = '0; done_c = 1'b1;
            end else begin
              sda_d   = shift_q[ByteW-1];
              shift_d = shift_q << 1;
              bit_d   = bit_q + i2cms_pkg::BitCntW'(1);
              phase_d = PH_TX_SET; hold_d = hold2;
            end
          end
          PH_RX_LO: begin
            scl_d   = 1'b1;
            shift_d = {shift_q[ByteW-2:0], in_i.sda_in};
            bit_d   = bit_q + i2cms_pkg::BitCntW'(1);
            phase_d = PH_RX_HI; hold_d = hold1;
          end
          PH_RX_HI: begin
            if (bit_q >= i2cms_pkg::BitCntW'(i2cms_pkg::BitsPerByte)) begin
              rx_d  = shift_q;
              scl_d = 1'b0; drv_d = 1'b1; sda_d = ~ackb_q;
              phase_d = PH_AK_A; hold_d = hold2;
            end else begin
              scl_d = 1'b0; phase_d = PH_RX_LO; hold_d = hold5;
            end
          end
          PH_AK_A:   begin scl_d = 1'b1; phase_d = PH_AK_B; hold_d = hold2; end
          PH_AK_B:   begin scl_d = 1'b0; phase_d = PH_IDLE; hold_d = '0; done_c = 1'b1; end
          default:   begin phase_d = PH_IDLE; hold_d = '0; done_c = 1'b1; end
        endcase
      end

      // ack poll: low SDA ends the wait, too many high samples send a stop
      if (do_poll) begin
        priority if (!in_i.sda_in) begin
          scl_d = 1'b0; phase_d = PH_IDLE; hold_d = '0; done_c = 1'b1;
        end else if (tmo_q >= tmo_lim_q) begin
          err_d = 1'b1;
          drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
          phase_d = PH_SP_A; hold_d = hold5;
        end else begin
          tmo_d = tmo_q + i2cms_pkg::TmoW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hold_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      tmo_q   <= '0;
      ackb_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
      err_q   <= 1'b0;
      rx_q    <= '0;
    end else begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      tmo_q   <= tmo_d;
      ackb_q  <= ackb_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
      err_q   <= err_d;
      rx_q    <= rx_d;
    end
  end

  // 2-entry result buffer
  i2cms_pkg::result_t res_c;
  i2cms_pkg::result_t obuf_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;

  assign res_c = '{
    scl_level: scl_d,
    sda_level: sda_d,
    sda_drive: drv_d,
    busy_res:  (phase_d != PH_IDLE),
    done_res:  done_c,
    rx_byte:   rx_d,
    ack_error: err_d
  };

  assign in_i.ready = (cnt_q != 2'd2);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_o.valid = (cnt_q != 2'd0);
  assign out_fire   = out_o.valid & out_o.ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      obuf_q[wr_ptr_q] <= res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (in_fire)  wr_ptr_q <= ~wr_ptr_q;
      if (out_fire) rd_ptr_q <= ~rd_ptr_q;
      unique case ({in_fire, out_fire})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign out_o.scl_level = obuf_q[rd_ptr_q].scl_level;
  assign out_o.sda_level = obuf_q[rd_ptr_q].sda_level;
  assign out_o.sda_drive = obuf_q[rd_ptr_q].sda_drive;
  assign out_o.busy_res  = obuf_q[rd_ptr_q].busy_res;
  assign out_o.done_res  = obuf_q[rd_ptr_q].done_res;
  assign out_o.rx_byte   = obuf_q[rd_ptr_q].rx_byte;
  assign out_o.ack_error = obuf_q[rd_ptr_q].ack_error;

  // a completing item is never reported as busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && done_c |-> phase_d == PH_IDLE)
    else $error("done with sequence still running");

  // every timed phase holds a nonzero count
  a_hold_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE && phase_q != PH_WA_POLL |-> hold_q != '0)
    else $error("timed phase with empty hold count");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= i2cms_pkg::BitCntW'(i2cms_pkg::BitsPerByte))
    else $error("bit counter past byte length");

  a_buf_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !out_fire |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("result buffer lost an item");

  a_poll_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && do_poll |-> phase_q == PH_WA_POLL || phase_q == PH_WA_B)
    else $error("ack poll outside ack wait");

endmodule

FILE: tb/i2c_master_byte_sequencer_top_tb.sv
`timescale 1ns / 1ps

module i2c_master_byte_sequencer_top_tb;

  localparam int unsigned OpW         = i2cms_pkg::OpW;
  localparam int unsigned ByteW       = i2cms_pkg::ByteW;
  localparam int unsigned HoldW       = i2cms_pkg::HoldW;
  localparam int unsigned BitCntW     = i2cms_pkg::BitCntW;
  localparam int unsigned TmoW        = i2cms_pkg::TmoW;
  localparam int unsigned TpmW        = i2cms_pkg::TpmW;
  localparam int unsigned CfgIdxW     = i2cms_pkg::CfgIdxW;
  localparam int unsigned BitsPerByte = i2cms_pkg::BitsPerByte;

  localparam int unsigned StuckLimit = 1000;
  localparam int unsigned HoldLongUs = 5;
  localparam int unsigned HoldMidUs  = 2;
  localparam int unsigned HoldShortUs = 1;

  // operation codes the block does not define
  localparam logic [OpW-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OpW-1:0] OP_UNDEF_HI = 3'd7;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_START_A, SQ_START_B, SQ_STOP_A, SQ_STOP_B, SQ_STOP_C,
    SQ_WAIT_A, SQ_WAIT_B, SQ_ACK_POLL, SQ_TX_SETUP, SQ_TX_HIGH, SQ_TX_LOW,
    SQ_RX_LOW, SQ_RX_HIGH, SQ_ACKBIT_A, SQ_ACKBIT_B
  } seq_phase_e;

  typedef enum int unsigned {
    SDA_RANDOM, SDA_HIGH, SDA_MOSTLY_HIGH, SDA_LOW
  } sda_mode_e;

  typedef struct packed {
    logic             cmd_valid;
    logic [OpW-1:0]   operation;
    logic [ByteW-1:0] tx_byte;
    logic             send_ack;
    logic             sda_in;
  } tick_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [TpmW-1:0]    cfg_data_i;

  i2cms_in_if  in_if ();
  i2cms_out_if out_if ();

  i2c_master_byte_sequencer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // line sequencer prediction state
  seq_phase_e       ln_phase;
  logic [HoldW-1:0] ln_hold;
  logic [BitCntW-1:0] ln_bits;
  logic [ByteW-1:0] ln_shift;
  logic [TmoW-1:0]  ln_tmo_cnt;
  logic             ln_ack;
  logic             ln_scl, ln_sda, ln_drv;
  logic             ln_err;
  logic [ByteW-1:0] ln_rx;
  logic             ln_done;
  logic [TpmW-1:0]  ln_tpm;
  logic [TmoW-1:0]  ln_tmo;

  tick_t              tick_q[$];
  i2cms_pkg::result_t line_results_q[$];
  int unsigned cmd_count = 0;
  int unsigned cmds_seen = 0;
  bit          idle_seen = 1'b1;
  sda_mode_e   sda_mode = SDA_RANDOM;
  int unsigned errors = 0;

  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned src_wait = 0;
  int unsigned sink_wait = 0;
  int unsigned stuck_cycles = 0;
  tick_t       drv_tick;
  tick_t       mon_tick;
  i2cms_pkg::result_t want_r;

  function automatic void ln_enter(seq_phase_e nxt, int unsigned us);
    int unsigned t;
    t = (ln_tpm == '0) ? 1 : ln_tpm;
    ln_phase = nxt;
    ln_hold = HoldW'(us * t);
  endfunction

  function automatic void ln_finish();
    ln_phase = SQ_IDLE;
    ln_hold = '0;
    ln_done = 1'b1;
  endfunction

  function automatic void ln_stop_begin();
    ln_drv = 1'b1;
    ln_scl = 1'b0;
    ln_sda = 1'b0;
    ln_enter(SQ_STOP_A, HoldLongUs);
  endfunction

  function automatic void ln_ackbit_begin();
    ln_scl = 1'b0;
    ln_drv = 1'b1;
    ln_sda = ~ln_ack;
    ln_enter(SQ_ACKBIT_A, HoldMidUs);
  endfunction

  function automatic void ln_tx_bit();
    ln_sda = ln_shift[ByteW-1];
    ln_shift = ln_shift << 1;
    ln_bits = ln_bits + 1'b1;
    ln_enter(SQ_TX_SETUP, HoldMidUs);
  endfunction

  function automatic void ln_poll(logic sda);
    if (!sda) begin
      ln_scl = 1'b0;
      ln_finish();
    end else if (ln_tmo_cnt >= ln_tmo) begin
      ln_err = 1'b1;
      ln_stop_begin();
    end else begin
      ln_tmo_cnt = ln_tmo_cnt + 1'b1;
    end
  endfunction

  function automatic void ln_advance(logic sda);
    case (ln_phase)
      SQ_START_A: begin
        ln_sda = 1'b0;
        ln_enter(SQ_START_B, HoldLongUs);
      end
      SQ_START_B: begin
        ln_scl = 1'b0;
        ln_finish();
      end
      SQ_STOP_A: begin
        ln_scl = 1'b1;
        ln_enter(SQ_STOP_B, HoldShortUs);
      end
      SQ_STOP_B: begin
        ln_sda = 1'b1;
        ln_enter(SQ_STOP_C, HoldLongUs);
      end
      SQ_STOP_C: ln_finish();
      SQ_WAIT_A: begin
        ln_scl = 1'b1;
        ln_enter(SQ_WAIT_B, HoldMidUs);
      end
      SQ_WAIT_B: begin
        // first poll lands on the tick the SCL-high hold runs out
        ln_phase = SQ_ACK_POLL;
        ln_hold = '0;
        ln_poll(sda);
      end
      SQ_TX_SETUP: begin
        ln_scl = 1'b1;
        ln_enter(SQ_TX_HIGH, HoldLongUs);
      end
      SQ_TX_HIGH: begin
        ln_scl = 1'b0;
        ln_enter(SQ_TX_LOW, HoldMidUs);
      end
      SQ_TX_LOW: begin
        if (ln_bits >= BitsPerByte) ln_finish();
        else ln_tx_bit();
      end
      SQ_RX_LOW: begin
        ln_scl = 1'b1;
        ln_shift = {ln_shift[ByteW-2:0], sda};
        ln_bits = ln_bits + 1'b1;
        ln_enter(SQ_RX_HIGH, HoldShortUs);
      end
      SQ_RX_HIGH: begin
        if (ln_bits >= BitsPerByte) begin
          ln_rx = ln_shift;
          ln_ackbit_begin();
        end else begin
          ln_scl = 1'b0;
          ln_enter(SQ_RX_LOW, HoldLongUs);
        end
      end
      SQ_ACKBIT_A: begin
        ln_scl = 1'b1;
        ln_enter(SQ_ACKBIT_B, HoldMidUs);
      end
      SQ_ACKBIT_B: begin
        ln_scl = 1'b0;
        ln_finish();
      end
      default: ln_finish();
    endcase
  endfunction

  function automatic void ln_accept(logic [OpW-1:0] op, logic [ByteW-1:0] txb, logic ack);
    ln_ack = ack;
    case (op)
      i2cms_pkg::OP_START: begin
        ln_drv = 1'b1;
        ln_sda = 1'b1;
        ln_scl = 1'b1;
        ln_enter(SQ_START_A, HoldLongUs);
      end
      i2cms_pkg::OP_STOP: ln_stop_begin();
      i2cms_pkg::OP_SEND: begin
        ln_drv = 1'b1;
        ln_scl = 1'b0;
        ln_shift = txb;
        ln_bits = '0;
        ln_tx_bit();
      end
      i2cms_pkg::OP_READ: begin
        ln_sda = 1'b0;
        ln_drv = 1'b0;
        ln_scl = 1'b0;
        ln_shift = '0;
        ln_bits = '0;
        ln_enter(SQ_RX_LOW, HoldLongUs);
      end
      i2cms_pkg::OP_WAIT: begin
        ln_err = 1'b0;
        ln_tmo_cnt = '0;
        ln_scl = 1'b0;
        ln_drv = 1'b0;
        ln_enter(SQ_WAIT_A, HoldMidUs);
      end
      i2cms_pkg::OP_ACK: ln_ackbit_begin();
      default: ;
    endcase
  endfunction

  function automatic i2cms_pkg::result_t line_tick(tick_t t);
    i2cms_pkg::result_t r;
    ln_done = 1'b0;
    if (ln_phase == SQ_IDLE) begin
      if (t.cmd_valid) begin
        if (t.operation <= i2cms_pkg::OP_ACK) cmd_count++;
        ln_accept(t.operation, t.tx_byte, t.send_ack);
      end
    end else if (ln_phase == SQ_ACK_POLL) begin
      ln_poll(t.sda_in);
    end else if (ln_hold > 1) begin
      ln_hold = ln_hold - 1'b1;
    end else begin
      ln_advance(t.sda_in);
    end
    r.scl_level = ln_scl;
    r.sda_level = ln_sda;
    r.sda_drive = ln_drv;
    r.busy_res  = (ln_phase != SQ_IDLE);
    r.done_res  = ln_done;
    r.rx_byte   = ln_rx;
    r.ack_error = ln_err;
    return r;
  endfunction

  function automatic void check_field(string name, logic [ByteW-1:0] want,
                                      logic [ByteW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic logic sda_pick();
    case (sda_mode)
      SDA_HIGH:        return 1'b1;
      SDA_MOSTLY_HIGH: return ($urandom_range(0, 31) != 0);
      SDA_LOW:         return 1'b0;
      default:         return 1'($urandom);
    endcase
  endfunction

  function automatic tick_t rand_tick(bit with_cmd);
    tick_t t;
    t.cmd_valid = with_cmd;
    if ($urandom_range(0, 15) == 0) t.operation = OpW'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    else t.operation = OpW'($urandom_range(i2cms_pkg::OP_START, i2cms_pkg::OP_ACK));
    t.tx_byte = ByteW'($urandom);
    t.send_ack = 1'($urandom);
    // each command brings its own slave behavior on SDA
    if (with_cmd) sda_mode = sda_mode_e'($urandom_range(SDA_RANDOM, SDA_LOW));
    t.sda_in = sda_pick();
    return t;
  endfunction

  // source side: one item per tick, random gap after each item
  always @(negedge clk_i) begin
    if (rst_ni && !(in_if.valid && !in_taken)) begin
      if (src_wait > 0) begin
        src_wait--;
        in_if.valid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        drv_tick = tick_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.cmd_valid <= drv_tick.cmd_valid;
        in_if.operation <= drv_tick.operation;
        in_if.tx_byte   <= drv_tick.tx_byte;
        in_if.send_ack  <= drv_tick.send_ack;
        in_if.sda_in    <= drv_tick.sda_in;
        src_wait = $urandom_range(0, 9);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // sink side: random stall after each result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) sink_wait = $urandom_range(0, 9);
      if (sink_wait > 0) begin
        sink_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    in_taken  = rst_ni && in_if.valid && in_if.ready;
    out_taken = rst_ni && out_if.valid && out_if.ready;
    if (in_taken) begin
      mon_tick.cmd_valid = in_if.cmd_valid;
      mon_tick.operation = in_if.operation;
      mon_tick.tx_byte   = in_if.tx_byte;
      mon_tick.send_ack  = in_if.send_ack;
      mon_tick.sda_in    = in_if.sda_in;
      line_results_q.push_back(line_tick(mon_tick));
    end
    if (out_taken) begin
      if (line_results_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        want_r = line_results_q.pop_front();
        check_field("scl_level", want_r.scl_level, out_if.scl_level);
        check_field("sda_level", want_r.sda_level, out_if.sda_level);
        check_field("sda_drive", want_r.sda_drive, out_if.sda_drive);
        check_field("busy_res",  want_r.busy_res,  out_if.busy_res);
        check_field("done_res",  want_r.done_res,  out_if.done_res);
        check_field("rx_byte",   want_r.rx_byte,   out_if.rx_byte);
        check_field("ack_error", want_r.ack_error, out_if.ack_error);
      end
    end
    // snapshots for the stimulus loop, read a step later
    cmds_seen <= cmd_count;
    idle_seen <= (ln_phase == SQ_IDLE);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic push_cmd(logic [OpW-1:0] op, logic [ByteW-1:0] txb, logic ack,
                          sda_mode_e mode);
    tick_t t;
    @(posedge clk_i);
    sda_mode = mode;
    t.cmd_valid = 1'b1;
    t.operation = op;
    t.tx_byte = txb;
    t.send_ack = ack;
    t.sda_in = sda_pick();
    tick_q.push_back(t);
  endtask

  // feed plain ticks while a sequence runs, until every item is in and it is idle
  task automatic settle();
    forever begin
      @(posedge clk_i);
      if (tick_q.size() == 0 && !in_if.valid && ln_phase == SQ_IDLE) break;
      if (tick_q.size() == 0 && ln_phase != SQ_IDLE) tick_q.push_back(rand_tick(1'b0));
    end
  endtask

  task automatic run_cmd(logic [OpW-1:0] op, logic [ByteW-1:0] txb, logic ack,
                         sda_mode_e mode);
    push_cmd(op, txb, ack, mode);
    settle();
  endtask

  task automatic drain();
    settle();
    while (line_results_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(i2cms_pkg::cfg_idx_e idx, logic [TpmW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == i2cms_pkg::CFG_TICKS_PER_US) ln_tpm = val;
    else ln_tmo = val;
  endtask

  task automatic feed_random(int unsigned n);
    int unsigned goal;
    goal = cmds_seen + n;
    while (cmds_seen < goal) begin
      @(posedge clk_i);
      if (tick_q.size() < 2) begin
        // commands mostly when idle; a few land while busy and get dropped
        if (idle_seen) tick_q.push_back(rand_tick($urandom_range(0, 3) != 0));
        else tick_q.push_back(rand_tick($urandom_range(0, 9) == 0));
      end
    end
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.cmd_valid = 1'b0;
    in_if.operation = i2cms_pkg::OP_START;
    in_if.tx_byte   = '0;
    in_if.send_ack  = 1'b0;
    in_if.sda_in    = 1'b1;
    out_if.ready    = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = i2cms_pkg::CFG_TICKS_PER_US;
    cfg_data_i      = '0;
    rst_ni          = 1'b0;

    ln_tpm = i2cms_pkg::TpmReset;
    ln_tmo = i2cms_pkg::TmoReset;
    ln_phase = SQ_IDLE;
    ln_hold = '0;
    ln_bits = '0;
    ln_shift = '0;
    ln_tmo_cnt = '0;
    ln_ack = 1'b0;
    ln_scl = 1'b1;
    ln_sda = 1'b1;
    ln_drv = 1'b1;
    ln_err = 1'b0;
    ln_rx = '0;
    ln_done = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one ack wait that the slave answers
    run_cmd(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, SDA_LOW);
    drain();

    // fastest rate, zero timeout: first high poll fails
    cfg_write(i2cms_pkg::CFG_TICKS_PER_US, 8'd1);
    cfg_write(i2cms_pkg::CFG_ACK_TIMEOUT, 8'd0);
    run_cmd(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, SDA_HIGH);
    run_cmd(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, SDA_LOW);
    run_cmd(i2cms_pkg::OP_SEND, 8'hA5, 1'b1, SDA_RANDOM);
    run_cmd(i2cms_pkg::OP_READ, 8'h00, 1'b0, SDA_HIGH);
    run_cmd(i2cms_pkg::OP_READ, 8'hFF, 1'b1, SDA_LOW);
    run_cmd(i2cms_pkg::OP_ACK, 8'h00, 1'b0, SDA_RANDOM);
    run_cmd(i2cms_pkg::OP_ACK, 8'h00, 1'b1, SDA_RANDOM);
    run_cmd(OP_UNDEF_LO, 8'h5A, 1'b1, SDA_RANDOM);
    run_cmd(OP_UNDEF_HI, 8'hC3, 1'b0, SDA_RANDOM);
    // stop arriving mid-start is dropped
    push_cmd(i2cms_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM);
    push_cmd(i2cms_pkg::OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    settle();
    drain();

    // zero rate acts as one tick per us; longest ack wait
    cfg_write(i2cms_pkg::CFG_TICKS_PER_US, 8'd0);
    cfg_write(i2cms_pkg::CFG_ACK_TIMEOUT, 8'd255);
    run_cmd(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, SDA_HIGH);
    run_cmd(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, SDA_MOSTLY_HIGH);
    run_cmd(i2cms_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM);
    run_cmd(i2cms_pkg::OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    drain();

    // random commands with a short timeout
    cfg_write(i2cms_pkg::CFG_TICKS_PER_US, 8'd1);
    cfg_write(i2cms_pkg::CFG_ACK_TIMEOUT, 8'd2);
    feed_random(6);
    drain();

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/i2cms_pkg.sv
rtl/core/i2cms_in_if.sv
rtl/core/i2cms_out_if.sv
rtl/core/i2c_master_byte_sequencer_top.sv
tb/i2c_master_byte_sequencer_top_tb.sv
